/* design/svpid_pkg.sv */
package svpid_pkg;

  localparam int unsigned PWM_RANGE        = 4000;
  localparam int unsigned INTEGRATOR_LIMIT = 40000;
  localparam int unsigned ACTION_DIVISOR   = 10;
  localparam int unsigned PREV_ERROR_RESET = 14;

  localparam int unsigned GAIN_W   = 16;
  localparam int unsigned POS_W    = 32;
  localparam int unsigned SPEED_W  = 64;
  localparam int unsigned DUTY_W   = 12;
  localparam int unsigned INTEG_W  = 17;
  localparam int unsigned ERR_W    = 32;
  localparam int unsigned PPROD_W  = GAIN_W + 1 + ERR_W;
  localparam int unsigned ISUM_W   = PPROD_W + 1;
  localparam int unsigned DPROD_W  = GAIN_W + 1 + ERR_W + 1;
  localparam int unsigned ACT_W    = DPROD_W + 2;

  localparam int unsigned MAG_LIMIT = PWM_RANGE * ACTION_DIVISOR;
  localparam int unsigned MAG_W     = $clog2(MAG_LIMIT + 1);
  localparam int unsigned RECIP_SH  = MAG_W + 3;
  localparam longint unsigned RECIP = (64'd1 << RECIP_SH) / ACTION_DIVISOR + 1;

  localparam int unsigned CFG_ADDR_W = 4;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [1:0] REG_P_GAIN = 2'd0;
  localparam logic [1:0] REG_I_GAIN = 2'd1;
  localparam logic [1:0] REG_D_GAIN = 2'd2;
  localparam logic [1:0] REG_ORIENT = 2'd3;

  localparam logic [GAIN_W-1:0] P_GAIN_RESET = GAIN_W'(160);
  localparam logic [GAIN_W-1:0] I_GAIN_RESET = GAIN_W'(2);
  localparam logic [GAIN_W-1:0] D_GAIN_RESET = GAIN_W'(12);

endpackage

/* design/servo_position_pid.sv */
// an accepted control tick passes through every register stage below to reach its result beat
// throughput: one input beat per cycle while s_axis_tready is high, speed commands included
// four register stages (error, integrator and products, action sum, output)
// each with its own valid bit, so bubbles close up under back-pressure
// rst_ni clears the loop state (prev error loads PREV_ERROR_RESET) and the valid bits; gains return to defaults
module servo_position_pid import svpid_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [95:0]           s_axis_tdata,   // position[31:0], speed[95:32]
  input  logic                  s_axis_tuser,   // req_type
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [15:0]           m_axis_tdata,   // duty[11:0], direction_pin[12], zero
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic [GAIN_W-1:0] p_gain_q, i_gain_q, d_gain_q;
  logic              orient_q;
  logic              cfg_wr;

  logic [SPEED_W-1:0] target_q, speed_q;
  logic [POS_W-1:0]   last_pos_q;

  logic                     s1_valid_q, s2_valid_q, s3_valid_q, out_valid_q;
  logic signed [ERR_W-1:0]  s1_err_q, s1_err_d;
  logic signed [INTEG_W-1:0] integ_q, integ_d;
  logic signed [ERR_W-1:0]  prev_err_q;
  logic signed [PPROD_W-1:0] s2_p_q, s2_p_d;
  logic signed [DPROD_W-1:0] s2_d_q, s2_d_d;
  logic signed [ACT_W-1:0]  s3_act_q, s3_act_d;
  logic [DUTY_W-1:0]        duty_q, duty_d;
  logic                     dir_q, dir_d;

  logic out_ready, s3_ready, s2_ready, s1_ready;
  logic in_acc, tick_acc, cmd_acc, s1_adv, s2_adv, s3_adv;

  logic [SPEED_W-1:0]        tgt_next;
  logic signed [PPROD_W-1:0] i_prod;
  logic signed [ISUM_W-1:0]  i_sum;
  logic signed [ERR_W:0]     err_diff;
  logic                      act_neg, mag_big;
  logic [ACT_W-1:0]          mag_full;
  logic [2*MAG_W-1:0]        quot_prod;
  logic [DUTY_W-1:0]         quot;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_comb begin
    case (paddr[3:2])
      REG_P_GAIN: prdata = CFG_DATA_W'(p_gain_q);
      REG_I_GAIN: prdata = CFG_DATA_W'(i_gain_q);
      REG_D_GAIN: prdata = CFG_DATA_W'(d_gain_q);
      REG_ORIENT: prdata = CFG_DATA_W'(orient_q);
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_gain_q <= P_GAIN_RESET;
      i_gain_q <= I_GAIN_RESET;
      d_gain_q <= D_GAIN_RESET;
      orient_q <= 1'b0;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_P_GAIN: p_gain_q <= pwdata[GAIN_W-1:0];
        REG_I_GAIN: i_gain_q <= pwdata[GAIN_W-1:0];
        REG_D_GAIN: d_gain_q <= pwdata[GAIN_W-1:0];
        REG_ORIENT: orient_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  // stage handshake
  assign out_ready = ~out_valid_q | m_axis_tready;
  assign s3_ready  = ~s3_valid_q | out_ready;
  assign s2_ready  = ~s2_valid_q | s3_ready;
  assign s1_ready  = ~s1_valid_q | s2_ready;
  assign s3_adv    = s3_valid_q & out_ready;
  assign s2_adv    = s2_valid_q & s3_ready;
  assign s1_adv    = s1_valid_q & s2_ready;

  assign s_axis_tready = s1_ready;
  assign in_acc        = s_axis_tvalid & s_axis_tready;
  assign tick_acc      = in_acc & ~s_axis_tuser;
  assign cmd_acc       = in_acc & s_axis_tuser;

  // stage 1: target advance and position error
  assign tgt_next = target_q + speed_q;
  assign s1_err_d = $signed(tgt_next[SPEED_W-1:SPEED_W-POS_W] - s_axis_tdata[POS_W-1:0]);

  // stage 2: integrator with clamp, proportional and derivative products
  assign i_prod   = $signed({1'b0, i_gain_q}) * s1_err_q;
  assign i_sum    = ISUM_W'(integ_q) + ISUM_W'(i_prod);
  assign err_diff = (ERR_W+1)'(prev_err_q) - (ERR_W+1)'(s1_err_q);
  assign s2_p_d   = $signed({1'b0, p_gain_q}) * s1_err_q;
  assign s2_d_d   = $signed({1'b0, d_gain_q}) * err_diff;

  always_comb begin
    if (i_sum > $signed(ISUM_W'(INTEGRATOR_LIMIT))) begin
      integ_d = $signed(INTEG_W'(INTEGRATOR_LIMIT));
    end else if (i_sum < -$signed(ISUM_W'(INTEGRATOR_LIMIT))) begin
      integ_d = -$signed(INTEG_W'(INTEGRATOR_LIMIT));
    end else begin
      integ_d = i_sum[INTEG_W-1:0];
    end
  end

  // stage 3: action sum
  assign s3_act_d = ACT_W'(s2_p_q) + ACT_W'(integ_q) + ACT_W'(s2_d_q);

  // output stage: magnitude divided by ten, saturation, direction
  assign act_neg   = s3_act_q[ACT_W-1];
  assign mag_full  = act_neg ? ACT_W'(-s3_act_q) : ACT_W'(s3_act_q);
  assign mag_big   = mag_full >= ACT_W'(MAG_LIMIT);
  assign quot_prod = mag_full[MAG_W-1:0] * MAG_W'(RECIP);
  assign quot      = quot_prod[RECIP_SH +: DUTY_W];

  always_comb begin
    duty_d = mag_big ? DUTY_W'(PWM_RANGE) : quot;
    dir_d  = dir_q;
    if (mag_big || (quot != '0)) begin
      dir_d = act_neg ? orient_q : ~orient_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q    <= '0;
      speed_q     <= '0;
      last_pos_q  <= '0;
      integ_q     <= '0;
      prev_err_q  <= ERR_W'(PREV_ERROR_RESET);
      dir_q       <= 1'b0;
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_acc) begin
        speed_q  <= s_axis_tdata[POS_W +: SPEED_W];
        target_q <= {last_pos_q, {(SPEED_W-POS_W){1'b0}}};
      end else if (tick_acc) begin
        target_q   <= tgt_next;
        last_pos_q <= s_axis_tdata[POS_W-1:0];
      end
      if (s1_ready) begin
        s1_valid_q <= tick_acc;
      end
      if (s2_ready) begin
        s2_valid_q <= s1_adv;
      end
      if (s1_adv) begin
        integ_q    <= integ_d;
        prev_err_q <= s1_err_q;
      end
      if (s3_ready) begin
        s3_valid_q <= s2_adv;
      end
      if (out_ready) begin
        out_valid_q <= s3_adv;
      end
      if (s3_adv) begin
        dir_q <= dir_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (tick_acc) begin
      s1_err_q <= s1_err_d;
    end
    if (s1_adv) begin
      s2_p_q <= s2_p_d;
      s2_d_q <= s2_d_d;
    end
    if (s2_adv) begin
      s3_act_q <= s3_act_d;
    end
    if (s3_adv) begin
      duty_q <= duty_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, dir_q, duty_q};

  a_integ_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (integ_q <= $signed(INTEG_W'(INTEGRATOR_LIMIT)))
      && (integ_q >= -$signed(INTEG_W'(INTEGRATOR_LIMIT))))
    else $error("integrator beyond clamp");

  a_duty_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (duty_q <= DUTY_W'(PWM_RANGE)))
    else $error("duty above pwm range");

  a_cmd_target: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_acc |=> (target_q == {$past(last_pos_q), {(SPEED_W-POS_W){1'b0}}}))
    else $error("speed command did not rebase target");

  a_cmd_no_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_acc && !s1_valid_q) |=> !s1_valid_q)
    else $error("speed command entered the pipeline");

  a_zero_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s3_adv && !mag_big && (quot == '0)) |=> $stable(dir_q))
    else $error("direction moved on zero action");

endmodule
